[design/aes128_pkg.sv]
// AES-128 package: S-box tables, round constants and round-step functions.
// No dependencies; imported by aes128_block_cipher_unit.
`default_nettype none
package aes128_pkg;

  typedef logic [7:0]   byte_t;
  typedef logic [127:0] blk_t;
  typedef byte_t        sbox_t [256];

  localparam int unsigned NumRounds = 10;

  // Register indexes of the configuration port.
  typedef enum logic [0:0] {
    CFG_KEY_UPPER = 1'b0,
    CFG_KEY_LOWER = 1'b1
  } cfg_idx_t;

  localparam sbox_t FWD_SBOX = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  // Reverse box built at elaboration from the forward box.
  function automatic sbox_t gen_rev_box();
    sbox_t t;
    for (int i = 0; i < 256; i++) begin
      t[FWD_SBOX[i]] = byte_t'(i);
    end
    return t;
  endfunction

  localparam sbox_t REV_SBOX = gen_rev_box();

  function automatic byte_t rcon(input logic [3:0] idx);
    byte_t r;
    unique case (idx)
      4'd1:    r = 8'h01;
      4'd2:    r = 8'h02;
      4'd3:    r = 8'h04;
      4'd4:    r = 8'h08;
      4'd5:    r = 8'h10;
      4'd6:    r = 8'h20;
      4'd7:    r = 8'h40;
      4'd8:    r = 8'h80;
      4'd9:    r = 8'h1b;
      4'd10:   r = 8'h36;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic byte_t get_b(input blk_t s, input int i);
    return s[127-8*i -: 8];
  endfunction

  function automatic byte_t xt(input byte_t b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic blk_t sub_bytes(input blk_t s);
    blk_t t;
    for (int i = 0; i < 16; i++) t[127-8*i -: 8] = FWD_SBOX[get_b(s, i)];
    return t;
  endfunction

  function automatic blk_t inv_sub_bytes(input blk_t s);
    blk_t t;
    for (int i = 0; i < 16; i++) t[127-8*i -: 8] = REV_SBOX[get_b(s, i)];
    return t;
  endfunction

  function automatic blk_t shift_rows(input blk_t s);
    blk_t t;
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++)
        t[127-8*(4*c+r) -: 8] = get_b(s, 4*((c + r) % 4) + r);
    return t;
  endfunction

  function automatic blk_t inv_shift_rows(input blk_t s);
    blk_t t;
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++)
        t[127-8*(4*c+r) -: 8] = get_b(s, 4*((c + 4 - r) % 4) + r);
    return t;
  endfunction

  function automatic blk_t mix_cols(input blk_t s);
    blk_t  t;
    byte_t a0, a1, a2, a3;
    for (int c = 0; c < 4; c++) begin
      a0 = get_b(s, 4*c);   a1 = get_b(s, 4*c+1);
      a2 = get_b(s, 4*c+2); a3 = get_b(s, 4*c+3);
      t[127-8*(4*c)   -: 8] = xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3;
      t[127-8*(4*c+1) -: 8] = a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3;
      t[127-8*(4*c+2) -: 8] = a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3;
      t[127-8*(4*c+3) -: 8] = xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3);
    end
    return t;
  endfunction

  // Multiply by 9, 11, 13, 14 via shared doublings.
  function automatic byte_t m9(input byte_t b);
    return xt(xt(xt(b))) ^ b;
  endfunction
  function automatic byte_t m11(input byte_t b);
    return xt(xt(xt(b))) ^ xt(b) ^ b;
  endfunction
  function automatic byte_t m13(input byte_t b);
    return xt(xt(xt(b))) ^ xt(xt(b)) ^ b;
  endfunction
  function automatic byte_t m14(input byte_t b);
    return xt(xt(xt(b))) ^ xt(xt(b)) ^ xt(b);
  endfunction

  function automatic blk_t inv_mix_cols(input blk_t s);
    blk_t  t;
    byte_t a0, a1, a2, a3;
    for (int c = 0; c < 4; c++) begin
      a0 = get_b(s, 4*c);   a1 = get_b(s, 4*c+1);
      a2 = get_b(s, 4*c+2); a3 = get_b(s, 4*c+3);
      t[127-8*(4*c)   -: 8] = m14(a0) ^ m11(a1) ^ m13(a2) ^ m9(a3);
      t[127-8*(4*c+1) -: 8] = m9(a0) ^ m14(a1) ^ m11(a2) ^ m13(a3);
      t[127-8*(4*c+2) -: 8] = m13(a0) ^ m9(a1) ^ m14(a2) ^ m11(a3);
      t[127-8*(4*c+3) -: 8] = m11(a0) ^ m13(a1) ^ m9(a2) ^ m14(a3);
    end
    return t;
  endfunction

  // One key-schedule step: round key of index idx from the previous one.
  function automatic blk_t next_rkey(input blk_t k, input logic [3:0] idx);
    logic [31:0] w0, w1, w2, w3, t;
    w0 = k[127:96]; w1 = k[95:64]; w2 = k[63:32]; w3 = k[31:0];
    t  = {FWD_SBOX[w3[23:16]] ^ rcon(idx), FWD_SBOX[w3[15:8]],
          FWD_SBOX[w3[7:0]], FWD_SBOX[w3[31:24]]};
    w0 = w0 ^ t;
    w1 = w1 ^ w0;
    w2 = w2 ^ w1;
    w3 = w3 ^ w2;
    return {w0, w1, w2, w3};
  endfunction

endpackage
`default_nettype wire

[design/aes128_block_cipher_unit.sv]
// AES-128 encrypt/decrypt core: 11-stage round pipeline plus key schedule.
// Depends on aes128_pkg (tables and round functions).
`default_nettype none
//
//  channel | ports                                  | direction
//  --------+----------------------------------------+-----------
//  input   | in_valid, in_stall, in_action, in_block_* | in (stall out)
//  result  | out_valid, out_stall, out_upper/lower  | out (stall in)
//  config  | cfg_we, cfg_index, cfg_wdata           | in
//
// One register stage for the initial key add and one per round; a new
// transaction may enter every cycle while in_stall is low.
// A key write (and reset) starts the key schedule sequencer, one round key
// per cycle; in_stall stays high while it runs.
// Reset is synchronous, active low; it clears valids and the key to zero.
// A held result freezes the whole pipeline; nothing is dropped or repeated.
module aes128_block_cipher_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_action,
  input  wire logic [63:0] in_block_upper,
  input  wire logic [63:0] in_block_lower,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [63:0]      out_upper,
  output logic [63:0]      out_lower,
  input  wire logic        cfg_we,
  input  wire aes128_pkg::cfg_idx_t cfg_index,
  input  wire logic [63:0] cfg_wdata
);
  import aes128_pkg::*;

  localparam int NStg = NumRounds + 1;

  // Key schedule state
  logic [63:0] key_hi_r, key_lo_r, key_hi_nxt, key_lo_nxt;
  blk_t        rk_r [NStg];
  blk_t        prev_r;        // last round key produced
  logic [3:0]  cnt_r;         // index of the next round key
  logic        busy_r;

  // Pipeline state
  blk_t        st_r  [NStg];
  blk_t        st_nxt[NStg];
  logic        act_r [NStg];
  logic        vld_r [NStg];
  logic        adv;

  always_comb begin
    key_hi_nxt = key_hi_r;
    key_lo_nxt = key_lo_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_KEY_UPPER: key_hi_nxt = cfg_wdata;
        CFG_KEY_LOWER: key_lo_nxt = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_hi_r <= '0;
      key_lo_r <= '0;
      rk_r[0]  <= '0;
      prev_r   <= '0;
      cnt_r    <= 4'd1;
      busy_r   <= 1'b1;
    end else if (cfg_we) begin
      // Restart the schedule from the new key.
      key_hi_r <= key_hi_nxt;
      key_lo_r <= key_lo_nxt;
      rk_r[0]  <= {key_hi_nxt, key_lo_nxt};
      prev_r   <= {key_hi_nxt, key_lo_nxt};
      cnt_r    <= 4'd1;
      busy_r   <= 1'b1;
    end else if (busy_r) begin
      rk_r[cnt_r] <= next_rkey(prev_r, cnt_r);
      prev_r      <= next_rkey(prev_r, cnt_r);
      cnt_r       <= cnt_r + 4'd1;
      if (cnt_r == 4'(NumRounds)) busy_r <= 1'b0;
    end
  end

  // Whole pipe moves unless the output is held.
  assign adv      = ~(vld_r[NStg-1] & out_stall);
  assign in_stall = busy_r | ~adv;

  // Stage 0: whitening with round key 0 (encrypt) or 10 (decrypt).
  assign st_nxt[0] = {in_block_upper, in_block_lower}
                     ^ (in_action ? rk_r[NumRounds] : rk_r[0]);

  for (genvar k = 1; k < NStg; k++) begin : g_rnd
    blk_t enc_v, dec_v;
    always_comb begin
      enc_v = shift_rows(sub_bytes(st_r[k-1]));
      if (k != NumRounds) enc_v = mix_cols(enc_v);
      enc_v = enc_v ^ rk_r[k];
      dec_v = inv_sub_bytes(inv_shift_rows(st_r[k-1])) ^ rk_r[NumRounds-k];
      if (k != NumRounds) dec_v = inv_mix_cols(dec_v);
    end
    assign st_nxt[k] = act_r[k-1] ? dec_v : enc_v;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NStg; k++) vld_r[k] <= 1'b0;
    end else if (adv) begin
      vld_r[0] <= in_valid & ~busy_r;
      for (int k = 1; k < NStg; k++) vld_r[k] <= vld_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st_r[0]  <= st_nxt[0];
      act_r[0] <= in_action;
      for (int k = 1; k < NStg; k++) begin
        st_r[k]  <= st_nxt[k];
        act_r[k] <= act_r[k-1];
      end
    end
  end

  assign out_valid = vld_r[NStg-1];
  assign out_upper = st_r[NStg-1][127:64];
  assign out_lower = st_r[NStg-1][63:0];

endmodule
`default_nettype wire

[dv/testbench.sv]
// Self-checking testbench for aes128_block_cipher_unit: directed and random
// encrypt/decrypt transactions checked against an in-bench AES-128 predictor.
// Depends on aes128_pkg (cfg_idx_t) and the design.
`timescale 1ns / 1ps

class cipher_scoreboard;
  logic [127:0] pending_blocks[$];
  int unsigned  mismatches;
  int unsigned  checked;

  function void note_block(logic [127:0] expected);
    pending_blocks = {pending_blocks, expected};
  endfunction

  function void check_block(logic [63:0] got_upper, logic [63:0] got_lower);
    logic [127:0] want;
    if (pending_blocks.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected result %h %h", got_upper, got_lower);
      return;
    end
    want = pending_blocks.pop_front();
    checked++;
    if (want[127:64] !== got_upper) begin
      mismatches++;
      if (mismatches <= 10)
        $display("out_upper mismatch: expected %h got %h", want[127:64], got_upper);
    end
    if (want[63:0] !== got_lower) begin
      mismatches++;
      if (mismatches <= 10)
        $display("out_lower mismatch: expected %h got %h", want[63:0], got_lower);
    end
  endfunction
endclass

module testbench;
  import aes128_pkg::*;

  localparam int unsigned StallLimit = 20000;
  localparam int unsigned RandomItems = 1300;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_action = 1'b0;
  logic [63:0] in_block_upper = '0;
  logic [63:0] in_block_lower = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [63:0] out_upper;
  logic [63:0] out_lower;
  logic        cfg_we = 1'b0;
  cfg_idx_t    cfg_index = CFG_KEY_UPPER;
  logic [63:0] cfg_wdata = '0;

  aes128_block_cipher_unit dut (
    .clk, .rst_n, .in_valid, .in_stall, .in_action, .in_block_upper,
    .in_block_lower, .out_valid, .out_stall, .out_upper, .out_lower,
    .cfg_we, .cfg_index, .cfg_wdata
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------
  // Predictor: own S-box, key expansion and cipher rounds.
  // Byte i of a 128-bit state sits at bits [127-8i -: 8].
  // ---------------------------------------------------------------------
  logic [7:0]   sbox_fwd[256];
  logic [7:0]   sbox_inv[256];
  logic [63:0]  key_hi, key_lo;
  logic [127:0] sched[11];

  function automatic logic [7:0] dbl(logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gf_mul(logic [7:0] a, logic [7:0] b);
    logic [7:0] acc;
    acc = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) acc ^= a;
      a = dbl(a);
    end
    return acc;
  endfunction

  // Build the S-box from the field inverse plus the affine map.
  task automatic build_sboxes();
    logic [7:0] inv_v, x;
    for (int v = 0; v < 256; v++) begin
      inv_v = 8'h00;
      for (int c = 1; c < 256; c++)
        if (v != 0 && gf_mul(8'(v), 8'(c)) == 8'h01) inv_v = 8'(c);
      x = inv_v ^ {inv_v[6:0], inv_v[7]} ^ {inv_v[5:0], inv_v[7:6]}
          ^ {inv_v[4:0], inv_v[7:5]} ^ {inv_v[3:0], inv_v[7:4]} ^ 8'h63;
      sbox_fwd[v] = x;
      sbox_inv[x] = 8'(v);
    end
  endtask

  task automatic expand_schedule();
    logic [31:0] w[44];
    logic [31:0] t;
    logic [7:0]  rc;
    logic [127:0] k;
    k = {key_hi, key_lo};
    for (int i = 0; i < 4; i++) w[i] = k[127-32*i -: 32];
    rc = 8'h01;
    for (int i = 4; i < 44; i++) begin
      t = w[i-1];
      if (i % 4 == 0) begin
        t = {sbox_fwd[t[23:16]] ^ rc, sbox_fwd[t[15:8]], sbox_fwd[t[7:0]],
             sbox_fwd[t[31:24]]};
        rc = dbl(rc);
      end
      w[i] = w[i-4] ^ t;
    end
    for (int r = 0; r < 11; r++) sched[r] = {w[4*r], w[4*r+1], w[4*r+2], w[4*r+3]};
  endtask

  function automatic logic [127:0] permute_rows(logic [127:0] s, bit inverse);
    logic [127:0] t;
    int src;
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++) begin
        src = inverse ? 4*((c + 4 - r) % 4) + r : 4*((c + r) % 4) + r;
        t[127-8*(4*c+r) -: 8] = s[127-8*src -: 8];
      end
    return t;
  endfunction

  function automatic logic [127:0] mix(logic [127:0] s, bit inverse);
    logic [7:0] coef[4];
    logic [7:0] acc;
    logic [127:0] t;
    if (inverse) coef = '{8'd14, 8'd11, 8'd13, 8'd9};
    else coef = '{8'd2, 8'd3, 8'd1, 8'd1};
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++) begin
        acc = 8'h00;
        for (int i = 0; i < 4; i++)
          acc ^= gf_mul(s[127-8*(4*c+i) -: 8], coef[(i - r + 4) % 4]);
        t[127-8*(4*c+r) -: 8] = acc;
      end
    return t;
  endfunction

  function automatic logic [127:0] substitute(logic [127:0] s, bit inverse);
    logic [127:0] t;
    for (int i = 0; i < 16; i++)
      t[127-8*i -: 8] = inverse ? sbox_inv[s[127-8*i -: 8]] : sbox_fwd[s[127-8*i -: 8]];
    return t;
  endfunction

  function automatic logic [127:0] cipher_block(bit decrypt, logic [127:0] s);
    if (!decrypt) begin
      s ^= sched[0];
      for (int r = 1; r <= 10; r++) begin
        s = permute_rows(substitute(s, 1'b0), 1'b0);
        if (r != 10) s = mix(s, 1'b0);
        s ^= sched[r];
      end
    end else begin
      s ^= sched[10];
      for (int r = 9; r >= 0; r--) begin
        s = substitute(permute_rows(s, 1'b1), 1'b1);
        s ^= sched[r];
        if (r != 0) s = mix(s, 1'b1);
      end
    end
    return s;
  endfunction

  // ---------------------------------------------------------------------
  // Scoreboard, monitor and watchdog
  // ---------------------------------------------------------------------
  cipher_scoreboard board = new();
  int unsigned idle_cycles;
  bit          timed_out;
  int unsigned encrypts, decrypts;

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) board.check_block(out_upper, out_lower);
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  // Receiver stalls: mostly short bursts, sometimes long, with calm stretches.
  int unsigned calm;
  always @(posedge clk) begin
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (calm > 0) begin
      calm <= calm - 1;
      out_stall <= 1'b0;
    end else if (pick < 3) begin
      calm <= $urandom_range(20, 200);
      out_stall <= 1'b0;
    end else if (pick < 5) begin
      out_stall <= 1'b1;
      calm <= 0;
      repeat ($urandom_range(10, 40)) @(posedge clk);
    end else begin
      out_stall <= (pick < 30);
    end
  end

  function automatic int unsigned gap_len();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 60) return 0;
    if (pick < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Drive one transaction; valid stays high across back-to-back items.
  task automatic send_block(bit decrypt, logic [63:0] hi, logic [63:0] lo, bit no_gap);
    int unsigned gap;
    gap = no_gap ? 0 : gap_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_action      <= decrypt;
    in_block_upper <= hi;
    in_block_lower <= lo;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_block(cipher_block(decrypt, {hi, lo}));
    if (decrypt) decrypts++;
    else encrypts++;
  endtask

  // Wait out every pending result, then let the clock run on with valid low.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.pending_blocks.size() != 0 && !timed_out) @(posedge clk);
    repeat (15) @(posedge clk);
  endtask

  task automatic write_key(cfg_idx_t idx, logic [63:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_KEY_UPPER) key_hi = value;
    else key_lo = value;
    expand_schedule();
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  initial begin
    timed_out = 1'b0;
    wait (idle_cycles >= StallLimit);
    timed_out = 1'b1;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    logic [63:0] hi, lo;
    logic [127:0] ct;
    build_sboxes();
    key_hi = '0;
    key_lo = '0;
    expand_schedule();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: all-zero key after reset, field extremes, both actions.
    send_block(1'b0, '0, '0, 1'b0);
    send_block(1'b1, '0, '0, 1'b0);
    send_block(1'b0, '1, '1, 1'b0);
    send_block(1'b1, '1, '1, 1'b1);
    send_block(1'b0, 64'h0011223344556677, 64'h8899aabbccddeeff, 1'b1);
    drain();

    // Standard known-answer key, then a half-written key (upper only).
    write_key(CFG_KEY_UPPER, 64'h0001020304050607);
    write_key(CFG_KEY_LOWER, 64'h08090a0b0c0d0e0f);
    send_block(1'b0, 64'h0011223344556677, 64'h8899aabbccddeeff, 1'b0);
    send_block(1'b1, 64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a, 1'b1);
    send_block(1'b0, 64'h8000000000000000, 64'h0000000000000001, 1'b0);
    drain();
    write_key(CFG_KEY_UPPER, '1);
    send_block(1'b0, 64'h5555555555555555, 64'haaaaaaaaaaaaaaaa, 1'b0);
    send_block(1'b1, 64'haaaaaaaaaaaaaaaa, 64'h5555555555555555, 1'b0);
    drain();
    write_key(CFG_KEY_LOWER, '1);
    send_block(1'b0, '0, '1, 1'b0);
    send_block(1'b1, '1, '0, 1'b0);
    drain();

    // Random phases, each under a fresh key; in every phase some blocks round-trip.
    for (int phase = 0; phase < 13; phase++) begin
      write_key(CFG_KEY_UPPER, phase == 12 ? 64'h0 : rand64());
      if ($urandom_range(0, 3) != 0) write_key(CFG_KEY_LOWER, rand64());
      for (int n = 0; n < RandomItems / 13; n++) begin
        hi = rand64();
        lo = rand64();
        if (n == 50) drain();  // sender holds off until the pipe is empty
        if ($urandom_range(0, 4) == 0) begin
          ct = cipher_block(1'b0, {hi, lo});
          send_block(1'b1, ct[127:64], ct[63:0], 1'b0);
        end else begin
          send_block(1'($urandom_range(0, 1)), hi, lo, 1'b0);
        end
      end
      drain();
    end

    $display("ran %0d encrypt and %0d decrypt transactions: reset key, directed keys",
             encrypts, decrypts);
    $display("and 13 random key phases; checked %0d results, %0d mismatches",
             board.checked, board.mismatches);
    if (board.mismatches == 0 && board.pending_blocks.size() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end
endmodule

[files.f]
design/aes128_pkg.sv
design/aes128_block_cipher_unit.sv
dv/testbench.sv
